FILE: sv/tftgw_pkg.sv
// tftgw_pkg: opcodes, byte constants and the descriptor type shared by the
// front, the queue and the back of the tft byte writer
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package tftgw_pkg;

    localparam int OPC_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 6;
    localparam int BITS_W  = 4;
    localparam int MAX_RUN_DEF = 32;
    localparam int Q_DEPTH = 4;

    localparam logic [OPC_W-1:0] OP_CMD   = 3'd0;
    localparam logic [OPC_W-1:0] OP_DATA  = 3'd1;
    localparam logic [OPC_W-1:0] OP_WIN   = 3'd2;
    localparam logic [OPC_W-1:0] OP_PIXEL = 3'd3;
    localparam logic [OPC_W-1:0] OP_GLYPH = 3'd4;
    localparam logic [OPC_W-1:0] OP_FILL  = 3'd5;

    localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;
    localparam logic [BYTE_W-1:0] ALL_ONES   = 8'hFF;

    localparam logic [BYTE_W-1:0] COL_OFF_RST = 8'd2;
    localparam logic [BYTE_W-1:0] ROW_OFF_RST = 8'd3;

    // configuration register indexes
    localparam logic REG_COL_OFF = 1'b0;
    localparam logic REG_ROW_OFF = 1'b1;

    // descriptor kinds handed from front to back
    localparam logic [1:0] K_RAW   = 2'd0;
    localparam logic [1:0] K_WIN   = 2'd1;
    localparam logic [1:0] K_COLOR = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_data;
        logic [BYTE_W-1:0] raw;
        logic [WORD_W-1:0] col_start;
        logic [WORD_W-1:0] col_end;
        logic [WORD_W-1:0] row_start;
        logic [WORD_W-1:0] row_end;
        logic [WORD_W-1:0] fg;
        logic [WORD_W-1:0] bg;
        logic [BYTE_W-1:0] bits;
        logic              fill_in;
        logic [CNT_W-1:0]  count;
    } t_desc;

    typedef struct packed {
        logic  we;
        logic  idx;
        logic [BYTE_W-1:0] data;
    } t_cfg;

endpackage
`default_nettype wire

FILE: sv/tft_window_glyph_byte_writer_top.sv
// a request is written into the descriptor queue, popped into the back
// sequencer and sent out byte by byte through the output register
// throughput: one byte per cycle while i_stall is low; a request has 1 raw,
// 11 window, 2 pixel, 2 to 16 glyph or 2 to 2*MAX_RUN fill bytes
// reset: synchronous active low, clears the queue and sequencer, and loads
// column offset 2 and row offset 3
`timescale 1ns / 1ps
`default_nettype none
module tft_window_glyph_byte_writer_top #(
    parameter int MAX_RUN = tftgw_pkg::MAX_RUN_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // configuration write port
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_idx,
    input  wire [tftgw_pkg::BYTE_W-1:0]  i_cfg_data,
    // request channel
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire [tftgw_pkg::OPC_W-1:0]   i_opcode,
    input  wire [tftgw_pkg::BYTE_W-1:0]  i_raw_byte,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_x_start,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_y_start,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_win_width,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_win_height,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_fg_color,
    input  wire [tftgw_pkg::WORD_W-1:0]  i_bg_color,
    input  wire [tftgw_pkg::BYTE_W-1:0]  i_font_bits,
    input  wire [tftgw_pkg::BITS_W-1:0]  i_bit_count,
    input  wire [tftgw_pkg::CNT_W-1:0]   i_run_length,
    // byte channel
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [tftgw_pkg::BYTE_W-1:0] o_out_byte,
    output logic                         o_is_data,
    output logic                         o_last
);
    import tftgw_pkg::*;

    t_cfg  cfg;
    t_desc front_desc;
    t_desc queue_desc;
    logic  produce;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    logic  q_push;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // the front only stalls when the queue is full; requests that make no
    // bytes are accepted and dropped
    assign o_stall = q_full;
    assign q_push  = i_valid && !q_full && produce;

    // front: offsets, window sums, saturation and classification
    tftgw_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_opcode     (i_opcode),
        .i_raw_byte   (i_raw_byte),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_win_width  (i_win_width),
        .i_win_height (i_win_height),
        .i_fg_color   (i_fg_color),
        .i_bg_color   (i_bg_color),
        .i_font_bits  (i_font_bits),
        .i_bit_count  (i_bit_count),
        .i_run_length (i_run_length),
        .o_produce    (produce),
        .o_desc       (front_desc)
    );

    // descriptor queue decouples the request side from the byte side
    tftgw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_desc  (queue_desc)
    );

    // back: one byte per cycle into the output register while i_stall is low
    tftgw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_desc     (queue_desc),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_data  (o_is_data),
        .o_last     (o_last)
    );

endmodule
`default_nettype wire

FILE: sv/tftgw_front.sv
// tftgw_front: holds the offset registers, classifies each request and
// builds a byte-sequence descriptor; uses tftgw_pkg
`timescale 1ns / 1ps
`default_nettype none
module tftgw_front #(
    parameter int MAX_RUN = tftgw_pkg::MAX_RUN_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  tftgw_pkg::t_cfg               i_cfg,
    input  wire [tftgw_pkg::OPC_W-1:0]    i_opcode,
    input  wire [tftgw_pkg::BYTE_W-1:0]   i_raw_byte,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_x_start,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_y_start,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_win_width,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_win_height,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_fg_color,
    input  wire [tftgw_pkg::WORD_W-1:0]   i_bg_color,
    input  wire [tftgw_pkg::BYTE_W-1:0]   i_font_bits,
    input  wire [tftgw_pkg::BITS_W-1:0]   i_bit_count,
    input  wire [tftgw_pkg::CNT_W-1:0]    i_run_length,
    output logic                          o_produce,
    output tftgw_pkg::t_desc              o_desc
);
    import tftgw_pkg::*;

    localparam logic [CNT_W-1:0]  RUN_MAX   = CNT_W'(MAX_RUN);
    localparam logic [BITS_W-1:0] GLYPH_MAX = BITS_W'(BYTE_W);

    logic [BYTE_W-1:0] r_col_off;
    logic [BYTE_W-1:0] r_row_off;
    logic [WORD_W-1:0] col_s;
    logic [WORD_W-1:0] row_s;
    logic [BITS_W-1:0] glyph_n;
    logic [CNT_W-1:0]  run_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off <= COL_OFF_RST;
            r_row_off <= ROW_OFF_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                REG_COL_OFF: r_col_off <= i_cfg.data;
                REG_ROW_OFF: r_row_off <= i_cfg.data;
                default:     r_col_off <= r_col_off;
            endcase
        end
    end

    always_comb begin
        col_s   = i_x_start + {{(WORD_W-BYTE_W){1'b0}}, r_col_off};
        row_s   = i_y_start + {{(WORD_W-BYTE_W){1'b0}}, r_row_off};
        glyph_n = (i_bit_count > GLYPH_MAX) ? GLYPH_MAX : i_bit_count;
        run_n   = (i_run_length > RUN_MAX) ? RUN_MAX : i_run_length;

        o_desc           = '0;
        o_desc.raw       = i_raw_byte;
        o_desc.is_data   = (i_opcode == OP_DATA);
        o_desc.col_start = col_s;
        o_desc.col_end   = col_s + i_win_width - WORD_W'(1);
        o_desc.row_start = row_s;
        o_desc.row_end   = row_s + i_win_height - WORD_W'(1);
        o_desc.fg        = i_fg_color;
        o_desc.bg        = i_bg_color;
        o_desc.bits      = ALL_ONES;
        o_desc.fill_in   = 1'b1;
        o_desc.count     = CNT_W'(1);
        o_produce        = 1'b1;

        unique case (i_opcode)
            OP_CMD, OP_DATA: o_desc.kind = K_RAW;
            OP_WIN:          o_desc.kind = K_WIN;
            OP_PIXEL:        o_desc.kind = K_COLOR;
            OP_GLYPH: begin
                o_desc.kind    = K_COLOR;
                o_desc.bits    = i_font_bits;
                o_desc.fill_in = 1'b0;
                o_desc.count   = {{(CNT_W-BITS_W){1'b0}}, glyph_n};
                o_produce      = (glyph_n != '0);
            end
            OP_FILL: begin
                o_desc.kind  = K_COLOR;
                o_desc.count = run_n;
                o_produce    = (run_n != '0);
            end
            default: begin
                // unused opcodes are swallowed
                o_desc.kind = K_RAW;
                o_produce   = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/tftgw_queue.sv
// tftgw_queue: short descriptor queue between front and back
// uses tftgw_pkg for the descriptor type and depth
`timescale 1ns / 1ps
`default_nettype none
module tftgw_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  tftgw_pkg::t_desc i_desc,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output tftgw_pkg::t_desc o_desc
);
    import tftgw_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_desc             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_QW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_QW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_QW'(1);
                2'b01:   r_cnt <= r_cnt - CNT_QW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/tftgw_back.sv
// tftgw_back: byte sequencer that walks one descriptor at a time and drives
// the output register; uses tftgw_pkg
`timescale 1ns / 1ps
`default_nettype none
module tftgw_back (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_empty,
    input  tftgw_pkg::t_desc            i_desc,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [tftgw_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_is_data,
    output logic                        o_last
);
    import tftgw_pkg::*;

    localparam logic [3:0] WIN_LAST = 4'd10;

    t_desc             r_cur;
    logic              r_busy;
    logic [3:0]        r_step;
    logic              r_half;
    logic [CNT_W-1:0]  r_left;
    logic [BYTE_W-1:0] r_bits;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_data;
    logic              r_out_last;

    logic              load_out;
    logic              emit;
    logic              done;
    logic [BYTE_W-1:0] cur_byte;
    logic              cur_data;
    logic              cur_last;
    logic [WORD_W-1:0] color;

    always_comb begin
        color    = r_bits[BYTE_W-1] ? r_cur.fg : r_cur.bg;
        cur_byte = r_cur.raw;
        cur_data = 1'b1;
        cur_last = 1'b0;
        unique case (r_cur.kind)
            K_RAW: begin
                cur_data = r_cur.is_data;
                cur_last = 1'b1;
            end
            K_WIN: begin
                unique case (r_step)
                    4'd0:    begin cur_byte = CMD_COLUMN; cur_data = 1'b0; end
                    4'd1:    cur_byte = r_cur.col_start[15:8];
                    4'd2:    cur_byte = r_cur.col_start[7:0];
                    4'd3:    cur_byte = r_cur.col_end[15:8];
                    4'd4:    cur_byte = r_cur.col_end[7:0];
                    4'd5:    begin cur_byte = CMD_ROW; cur_data = 1'b0; end
                    4'd6:    cur_byte = r_cur.row_start[15:8];
                    4'd7:    cur_byte = r_cur.row_start[7:0];
                    4'd8:    cur_byte = r_cur.row_end[15:8];
                    4'd9:    cur_byte = r_cur.row_end[7:0];
                    default: begin
                        cur_byte = CMD_WRITE;
                        cur_data = 1'b0;
                        cur_last = 1'b1;
                    end
                endcase
            end
            default: begin
                cur_byte = r_half ? color[7:0] : color[15:8];
                cur_last = r_half && (r_left == CNT_W'(1));
            end
        endcase
    end

    assign load_out = !r_out_valid || !i_stall;
    assign emit     = r_busy && load_out;
    assign done     = emit && cur_last;
    assign o_pop    = !i_empty && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_desc;
            r_step <= '0;
            r_half <= 1'b0;
            r_left <= i_desc.count;
            r_bits <= i_desc.bits;
        end else if (emit) begin
            r_step <= (r_step == WIN_LAST) ? r_step : r_step + 4'd1;
            r_half <= !r_half;
            if (r_half) begin
                r_left <= r_left - CNT_W'(1);
                r_bits <= {r_bits[BYTE_W-2:0], r_cur.fill_in};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_data <= cur_data;
            r_out_last <= cur_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_is_data  = r_out_data;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire

FILE: sv/tftgw_checker.sv
// tftgw_checker: port-level assertions on the byte channel, bound to the top
// depends on tftgw_pkg and the top level port names
`timescale 1ns / 1ps
`default_nettype none
module tftgw_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire [tftgw_pkg::BYTE_W-1:0]  o_out_byte,
    input wire                          o_is_data,
    input wire                          o_last
);
    import tftgw_pkg::*;

    // reset leaves no byte pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("byte valid after reset");

    // a stalled byte stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("byte dropped while stalled");

    // a stalled byte keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_byte) && $stable(o_is_data)
            && $stable(o_last))
        else $error("byte payload changed while stalled");

    // only the column and row address commands are commands that are not last
    a_mid_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_data && !o_last |-> o_out_byte == CMD_COLUMN
            || o_out_byte == CMD_ROW)
        else $error("unexpected command inside a sequence");

endmodule

bind tft_window_glyph_byte_writer_top tftgw_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_byte (o_out_byte),
    .o_is_data  (o_is_data),
    .o_last     (o_last)
);
`default_nettype wire

FILE: tb/sv/tb_tft_window_glyph_byte_writer_top.sv
// testbench for the tft window/glyph byte writer: queues drawing requests, predicts the
// panel byte stream per accepted request and checks every emitted byte in order
// depends on tftgw_pkg and tft_window_glyph_byte_writer_top
`timescale 1ns / 1ps
module tb_tft_window_glyph_byte_writer_top;
    import tftgw_pkg::*;

    // opcodes the block ignores
    localparam logic [OPC_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int MAX_RUN      = MAX_RUN_DEF;
    localparam int DRAIN_CYCLES = 8;     // slack for the pipe to empty
    localparam int STALL_LIMIT  = 4000;  // cycles with neither side accepting
    localparam int PHASE_ITEMS  = 56;    // five random phases, about 280 requests

    // one drawing request as the sender holds it
    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [BYTE_W-1:0] raw_byte;
        logic [WORD_W-1:0] x_start;
        logic [WORD_W-1:0] y_start;
        logic [WORD_W-1:0] win_width;
        logic [WORD_W-1:0] win_height;
        logic [WORD_W-1:0] fg_color;
        logic [WORD_W-1:0] bg_color;
        logic [BYTE_W-1:0] font_bits;
        logic [BITS_W-1:0] bit_count;
        logic [CNT_W-1:0]  run_length;
    } t_draw_req;

    // one byte headed for the panel
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_data;
        logic              last;
    } t_panel_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              i_cfg_we   = 1'b0;
    logic              i_cfg_idx  = REG_COL_OFF;
    logic [BYTE_W-1:0] i_cfg_data = '0;

    logic      i_valid = 1'b0;
    wire       o_stall;
    t_draw_req cur_req = '0;

    wire              o_valid;
    logic             i_stall = 1'b1;
    wire [BYTE_W-1:0] o_out_byte;
    wire              o_is_data;
    wire              o_last;

    tft_window_glyph_byte_writer_top #(
        .MAX_RUN(MAX_RUN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (cur_req.opcode),
        .i_raw_byte  (cur_req.raw_byte),
        .i_x_start   (cur_req.x_start),
        .i_y_start   (cur_req.y_start),
        .i_win_width (cur_req.win_width),
        .i_win_height(cur_req.win_height),
        .i_fg_color  (cur_req.fg_color),
        .i_bg_color  (cur_req.bg_color),
        .i_font_bits (cur_req.font_bits),
        .i_bit_count (cur_req.bit_count),
        .i_run_length(cur_req.run_length),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // shared bookkeeping
    t_draw_req   request_q[$];       // requests waiting for the driver
    t_panel_byte panel_bytes_due[$]; // predicted bytes not yet seen
    t_panel_byte burst_bytes[$];     // scratch for the request being expanded
    int          queued_total   = 0;
    int          accepted_total = 0;
    int          mismatch_cnt   = 0;
    int          idle_cycles    = 0;
    logic        req_fired      = 1'b0;

    // our copy of the offset registers
    logic [BYTE_W-1:0] col_off_model = COL_OFF_RST;
    logic [BYTE_W-1:0] row_off_model = ROW_OFF_RST;

    // ------------------------------------------------------------------
    // byte predictor
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic is_data);
        t_panel_byte pb;
        pb.out_byte = b;
        pb.is_data  = is_data;
        pb.last     = 1'b0;
        burst_bytes.push_back(pb);
    endtask

    // rgb565 goes out high byte first
    task automatic add_color(input logic [WORD_W-1:0] color);
        add_byte(color[15:8], 1'b1);
        add_byte(color[7:0], 1'b1);
    endtask

    // address command plus start and end, all sums wrap at 16 bits
    task automatic add_range(input logic [BYTE_W-1:0] cmd, input logic [WORD_W-1:0] pos,
                             input logic [BYTE_W-1:0] off, input logic [WORD_W-1:0] size);
        logic [WORD_W-1:0] first_pos;
        logic [WORD_W-1:0] end_pos;
        first_pos = pos + {8'd0, off};
        end_pos   = first_pos + size - 16'd1;  // zero size wraps to start minus one
        add_byte(cmd, 1'b0);
        add_byte(first_pos[15:8], 1'b1);
        add_byte(first_pos[7:0], 1'b1);
        add_byte(end_pos[15:8], 1'b1);
        add_byte(end_pos[7:0], 1'b1);
    endtask

    // expand one accepted request into the bytes it must produce
    task automatic expand_request(input t_draw_req r);
        int          pixels;
        logic [7:0]  bits;
        t_panel_byte pb;
        burst_bytes.delete();
        case (r.opcode)
            OP_CMD, OP_DATA: begin
                add_byte(r.raw_byte, r.opcode == OP_DATA);
            end
            OP_WIN: begin
                add_range(CMD_COLUMN, r.x_start, col_off_model, r.win_width);
                add_range(CMD_ROW, r.y_start, row_off_model, r.win_height);
                add_byte(CMD_WRITE, 1'b0);
            end
            OP_PIXEL: begin
                add_color(r.fg_color);
            end
            OP_GLYPH: begin
                // counts above 8 saturate, zero draws nothing
                pixels = (r.bit_count > 4'd8) ? 8 : int'(r.bit_count);
                bits   = r.font_bits;
                for (int i = 0; i < pixels; i++) begin
                    add_color(bits[7] ? r.fg_color : r.bg_color);
                    bits = bits << 1;
                end
            end
            OP_FILL: begin
                pixels = (int'(r.run_length) > MAX_RUN) ? MAX_RUN : int'(r.run_length);
                for (int i = 0; i < pixels; i++) begin
                    add_color(r.fg_color);
                end
            end
            default: begin
                // spare opcodes are swallowed
            end
        endcase
        for (int i = 0; i < burst_bytes.size(); i++) begin
            pb      = burst_bytes[i];
            pb.last = (i == burst_bytes.size() - 1);
            panel_bytes_due.push_back(pb);
        end
    endtask

    task automatic note_mismatch(input string what, input t_panel_byte want,
                                 input t_panel_byte got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t %s: expected byte %02h data %0b last %0b, got byte %02h data %0b last %0b",
                     $realtime, what, want.out_byte, want.is_data, want.last,
                     got.out_byte, got.is_data, got.last);
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: predicts on request acceptance, checks on byte acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_panel_byte got;
        t_panel_byte want;
        logic        req_take;
        logic        byte_take;
        req_take  = i_rst_n && i_valid && !o_stall;
        byte_take = i_rst_n && o_valid && !i_stall;
        req_fired <= req_take;

        if (req_take) begin
            expand_request(cur_req);
            accepted_total++;
        end

        if (byte_take) begin
            got.out_byte = o_out_byte;
            got.is_data  = o_is_data;
            got.last     = o_last;
            if (panel_bytes_due.size() == 0) begin
                note_mismatch("byte with none due", '0, got);
            end else begin
                want = panel_bytes_due.pop_front();
                if (got !== want) begin
                    note_mismatch("byte mismatch", want, got);
                end
            end
        end

        // watchdog: give up after a long stretch of no progress on either side
        if (req_take || byte_take || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tft_window_glyph_byte_writer_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // request driver: bursts of back-to-back requests with random gaps
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !req_fired) begin
            // request still pending, hold it
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (request_q.size() != 0) begin
            cur_req <= request_q.pop_front();
            i_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                // about a third of bursts run straight into the next one
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // byte receiver: random stalls, with the stall density redrawn whenever its random hold runs out
    // ------------------------------------------------------------------
    int stall_pct  = 0;
    int stall_hold = 0;

    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 20;
                2: stall_pct <= 50;
                default: stall_pct <= 85;
            endcase
            stall_hold <= $urandom_range(50, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_draw_req rand_req();
        t_draw_req r;
        int        sel;
        r.opcode     = OP_CMD;
        r.raw_byte   = BYTE_W'($urandom);
        r.x_start    = WORD_W'($urandom);
        r.y_start    = WORD_W'($urandom);
        r.win_width  = WORD_W'($urandom);
        r.win_height = WORD_W'($urandom);
        r.fg_color   = WORD_W'($urandom);
        r.bg_color   = WORD_W'($urandom);
        r.font_bits  = BYTE_W'($urandom);
        r.bit_count  = BITS_W'($urandom);
        r.run_length = CNT_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            r.opcode = OP_CMD;
        end else if (sel < 16) begin
            r.opcode = OP_DATA;
        end else if (sel < 32) begin
            r.opcode = OP_WIN;
            // now and then an empty dimension to exercise the wrap
            if ($urandom_range(0, 9) == 0) r.win_width  = '0;
            if ($urandom_range(0, 9) == 0) r.win_height = '0;
        end else if (sel < 47) begin
            r.opcode = OP_PIXEL;
        end else if (sel < 73) begin
            r.opcode = OP_GLYPH;
            if ($urandom_range(0, 6) != 0) r.bit_count = BITS_W'($urandom_range(1, 8));
        end else if (sel < 95) begin
            r.opcode = OP_FILL;
            // mostly short runs, a few long or out of range
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r.run_length = CNT_W'($urandom_range(1, 8));
                6, 7:             r.run_length = CNT_W'($urandom_range(9, MAX_RUN));
                default:          r.run_length = CNT_W'($urandom);
            endcase
        end else begin
            r.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return r;
    endfunction

    task automatic queue_req(input t_draw_req r);
        request_q.push_back(r);
        queued_total++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_req(rand_req());
        end
    endtask

    // wait for every request taken and every byte seen, then let the pipe empty
    task automatic wait_drained();
        while (accepted_total != queued_total || panel_bytes_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_offsets(input logic [BYTE_W-1:0] col, input logic [BYTE_W-1:0] row);
        @(negedge i_clk);
        i_cfg_we      <= 1'b1;
        i_cfg_idx     <= REG_COL_OFF;
        i_cfg_data    <= col;
        col_off_model  = col;
        @(negedge i_clk);
        i_cfg_idx     <= REG_ROW_OFF;
        i_cfg_data    <= row;
        row_off_model  = row;
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    initial begin
        t_draw_req r;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass with the reset offsets
        r = rand_req(); r.opcode = OP_CMD;  r.raw_byte = 8'h00;          queue_req(r);
        r = rand_req(); r.opcode = OP_DATA; r.raw_byte = 8'hFF;          queue_req(r);
        r = rand_req(); r.opcode = OP_CMD;  r.raw_byte = 8'hFF;          queue_req(r);
        r = rand_req(); r.opcode = OP_WIN;
        r.x_start = '0; r.y_start = '0; r.win_width = 16'd1; r.win_height = 16'd1;
        queue_req(r);
        // start and end both wrap past the top
        r.x_start = 16'hFFFF; r.y_start = 16'hFFFF;
        r.win_width = 16'hFFFF; r.win_height = 16'hFFFF;
        queue_req(r);
        // empty window: end lands one below start
        r.x_start = 16'h1234; r.y_start = 16'h00FE; r.win_width = '0; r.win_height = '0;
        queue_req(r);
        r = rand_req(); r.opcode = OP_PIXEL; r.fg_color = 16'h0000;      queue_req(r);
        r.fg_color = 16'hFFFF;                                           queue_req(r);
        r = rand_req(); r.opcode = OP_GLYPH;
        r.font_bits = 8'hA5; r.bit_count = 4'd8; r.fg_color = 16'hF800; r.bg_color = 16'h001F;
        queue_req(r);
        r.font_bits = 8'h80; r.bit_count = 4'd1;                         queue_req(r);
        r.font_bits = 8'hFF; r.bit_count = 4'd0;                         queue_req(r);
        r.font_bits = 8'h3C; r.bit_count = 4'd15;                        queue_req(r);
        r.font_bits = 8'h00; r.bit_count = 4'd9;                         queue_req(r);
        r = rand_req(); r.opcode = OP_FILL; r.run_length = 6'd1;         queue_req(r);
        r.run_length = 6'd32;                                            queue_req(r);
        r.run_length = 6'd0;                                             queue_req(r);
        r.run_length = 6'd63;                                            queue_req(r);
        r.run_length = 6'd33;                                            queue_req(r);
        r = rand_req(); r.opcode = OP_SPARE_6;                           queue_req(r);
        r = rand_req(); r.opcode = OP_SPARE_7;                           queue_req(r);
        r = rand_req(); r.opcode = OP_DATA; r.raw_byte = 8'h5A;          queue_req(r);
        wait_drained();

        // random phases across offset settings, extremes included
        write_offsets(8'd0, 8'd0);
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_offsets(8'hFF, 8'hFF);
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_offsets(BYTE_W'($urandom), BYTE_W'($urandom));
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_offsets(8'hFF, 8'd0);
        queue_random(PHASE_ITEMS);
        wait_drained();

        write_offsets(8'd0, 8'hFF);
        queue_random(PHASE_ITEMS);
        wait_drained();

        if (mismatch_cnt == 0) begin
            $display("tft_window_glyph_byte_writer_top: match");
        end else begin
            $display("tft_window_glyph_byte_writer_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tftgw_pkg.sv
sv/tftgw_front.sv
sv/tftgw_queue.sv
sv/tftgw_back.sv
sv/tft_window_glyph_byte_writer_top.sv
sv/tftgw_checker.sv
tb/sv/tb_tft_window_glyph_byte_writer_top.sv
